[src/tefc_pkg.sv]
`timescale 1ns / 1ps
// package: mode codes and conversion functions for the element format converter
package tefc_pkg;

    typedef enum logic [2:0] {
        MODE_F32_BF16 = 3'd0,
        MODE_F32_F16  = 3'd1,
        MODE_F32_U8   = 3'd2,
        MODE_BF16_F32 = 3'd3,
        MODE_F16_F32  = 3'd4
    } t_mode;

    localparam logic [31:0] C_F32_INF = 32'h7f80_0000;
    localparam logic [15:0] C_F16_INF = 16'h7c00;

    function automatic logic [31:0] enc_bf16(input logic [31:0] b);
        logic [31:0] s;
        s = b + 32'h0000_7fff + {31'd0, b[16]};
        return {16'd0, s[31:16]};
    endfunction

    function automatic logic [31:0] enc_fp16(input logic [31:0] b);
        logic [15:0] sign;
        logic [9:0]  ex;
        logic [23:0] man;
        logic [4:0]  sh;
        logic [23:0] sub;
        logic [15:0] r;
        sign = {b[31], 15'd0};
        ex   = {2'd0, b[30:23]} - 10'd112;
        man  = {1'b0, b[22:0]};
        sh   = 5'd0;
        sub  = 24'd0;
        r    = 16'd0;
        if (b[30:23] <= 8'd112) begin
            if (b[30:23] < 8'd102) begin
                r = sign;
            end else begin
                sh  = 5'(8'd113 - b[30:23]);
                sub = {1'b1, b[22:0]} >> sh;
                r   = sign | 16'((sub + 24'h1000) >> 13);
            end
        end else if (b[30:23] >= 8'd143) begin
            r = sign | C_F16_INF;
        end else begin
            r = sign | 16'(({6'd0, ex} << 10) + 16'((man + 24'h1000) >> 13));
        end
        return {16'd0, r};
    endfunction

    function automatic logic [31:0] enc_u8(input logic [31:0] b);
        logic [7:0]  e;
        logic [4:0]  sh;
        logic [24:0] r;
        logic [7:0]  res;
        e   = b[30:23];
        sh  = 5'd0;
        r   = 25'd0;
        if (e == 8'hff) begin
            res = (b[22:0] != 23'd0 || b[31]) ? 8'd0 : 8'd255;
        end else if (b[31] || e < 8'd126) begin
            res = 8'd0;
        end else if (e >= 8'd135) begin
            res = 8'd255;
        end else begin
            sh  = 5'(8'd150 - e);
            r   = ({1'b0, 1'b1, b[22:0]} + (25'd1 << (sh - 5'd1))) >> sh;
            res = (r > 25'd255) ? 8'd255 : r[7:0];
        end
        return {24'd0, res};
    endfunction

    function automatic logic [31:0] dec_fp16(input logic [15:0] h);
        logic [31:0] sign;
        logic [3:0]  lz;
        logic [9:0]  m;
        logic [7:0]  ex;
        logic [31:0] r;
        sign = {h[15], 31'd0};
        lz   = 4'd0;
        m    = h[9:0];
        ex   = 8'd0;
        for (int i = 0; i < 10; i++) begin
            if (h[i]) lz = 4'(9 - i);
        end
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0) begin
                r = sign;
            end else begin
                m  = h[9:0] << (lz + 4'd1);
                ex = 8'(8'd112 - {4'd0, lz});
                r  = sign | {1'b0, ex, m, 13'd0};
            end
        end else if (h[14:10] == 5'd31) begin
            r = sign | C_F32_INF | {9'd0, h[9:0], 13'd0};
        end else begin
            ex = {3'd0, h[14:10]} + 8'd112;
            r  = sign | {1'b0, ex, h[9:0], 13'd0};
        end
        return r;
    endfunction

endpackage

[src/tefc_conv.sv]
`timescale 1ns / 1ps
// combinational conversion selected by mode
module tefc_conv import tefc_pkg::*; (
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_value,
    output logic [31:0] o_result
);
    always_comb begin
        unique case (i_mode)
            MODE_F32_BF16: o_result = enc_bf16(i_value);
            MODE_F32_F16:  o_result = enc_fp16(i_value);
            MODE_F32_U8:   o_result = enc_u8(i_value);
            MODE_BF16_F32: o_result = {i_value[15:0], 16'd0};
            MODE_F16_F32:  o_result = dec_fp16(i_value[15:0]);
            default:       o_result = 32'd0;
        endcase
    end
endmodule

[src/tensor_element_format_converter.sv]
`timescale 1ns / 1ps
// top level: element format converter with input and result registers
// usage:
//   input channel i_valid/o_ready carries one word i_value_bits per item
//   result channel o_valid/i_ready carries o_result_bits, one per input word
//   config channel i_cfg_valid/o_cfg_ready writes the 3-bit format mode;
//   write only while no word is in flight
// path: an accepted word is held in the input register, then goes through
//   the conversion logic into the result register
// throughput: one word per cycle unless the receiver stalls; each register
//   stage advances whenever the stage after it is empty or being emptied
// a receiver stall backs up both stages, then o_ready drops
// reset empties both stages and sets the mode to fp32->bf16
module tensor_element_format_converter import tefc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);
    logic [2:0]  r_mode;
    logic        r_in_vld;
    logic [31:0] r_in;
    logic        r_out_vld;
    logic [31:0] r_out;
    logic [31:0] conv;
    logic        adv_out;

    assign adv_out     = !r_out_vld || i_ready;
    assign o_ready     = !r_in_vld || adv_out;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_result_bits = r_out;

    tefc_conv u_conv (.i_mode(r_mode), .i_value(r_in), .o_result(conv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_F32_BF16;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (o_ready) r_in_vld <= i_valid;
            if (adv_out) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_value_bits;
        if (adv_out && r_in_vld) r_out <= conv;
    end
endmodule

[src/tefc_checker.sv]
`timescale 1ns / 1ps
// port checker for the converter, bound to the top level
module tefc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_result_bits
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_bits))
        else $error("result word dropped or changed under stall");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> ##1 o_valid)
        else $error("accepted word did not reach output");
endmodule

bind tensor_element_format_converter tefc_checker u_tefc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_result_bits(o_result_bits)
);
